/* rtl/core/gif_first_image_filter_unit_assert.svh */
// ----------------------------------------------------------------------------
// gif filter assertion macros
// concurrent assertions clocked on clk_i, shared by gif_queue and gif_front
// ----------------------------------------------------------------------------
`ifndef GIF_FIRST_IMAGE_FILTER_UNIT_ASSERT_SVH
`define GIF_FIRST_IMAGE_FILTER_UNIT_ASSERT_SVH

// checked outside reset only
`define GIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define GIF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* rtl/core/gif_pkg.sv */
// ----------------------------------------------------------------------------
// gif filter package
// parser phases, item codes and byte constants shared by the filter modules
// ----------------------------------------------------------------------------
package gif_pkg;

  localparam int GIF_QUEUE_DEPTH = 4;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  // register index, taken from the word address bit of paddr
  localparam logic CFG_IDX_FIRST_IMAGE = 1'b0;

  localparam logic [7:0] BLK_IMAGE   = 8'h2c;
  localparam logic [7:0] BLK_EXT     = 8'h21;
  localparam logic [7:0] BLK_TRAILER = 8'h3b;

  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_8 = 8'h38;
  localparam logic [7:0] CH_7 = 8'h37;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h61;

  typedef enum logic [3:0] {
    PH_SIGNATURE = 4'd0,
    PH_SCREEN    = 4'd1,
    PH_BOUNDARY  = 4'd2,
    PH_IMAGEDESC = 4'd3,
    PH_CODESIZE  = 4'd4,
    PH_IMAGEDATA = 4'd5,
    PH_TRAILER   = 4'd6,
    PH_EXTINTRO  = 4'd7,
    PH_EXTTYPE   = 4'd8,
    PH_EXTDATA   = 4'd9,
    PH_COPYALL   = 4'd10,
    PH_DROPALL   = 4'd11
  } phase_e;

  typedef enum logic {
    OP_PASS    = 1'b0,
    OP_TRAILER = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } gif_item_t;

endpackage

/* rtl/core/gif_queue.sv */
// ----------------------------------------------------------------------------
// gif item queue
// small circular queue of classified items between the parser and the output
// ----------------------------------------------------------------------------
`include "gif_first_image_filter_unit_assert.svh"

module gif_queue #(
  parameter int Depth = gif_pkg::GIF_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gif_pkg::gif_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output gif_pkg::gif_item_t item_o,
  output logic               empty_o
);
  import gif_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  gif_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `GIF_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count above depth")
  `GIF_ASSERT_ALWAYS(a_full_not_empty, full_o |-> !empty_o, "queue full and empty at once")
  `GIF_ASSERT(a_no_push_full, full_o |-> !push_i, "item pushed into full queue")
  `GIF_ASSERT(a_no_pop_empty, empty_o |-> !pop_i, "item popped from empty queue")

endmodule

/* rtl/core/gif_front.sv */
// ----------------------------------------------------------------------------
// gif parser front end
// walks gif blocks one byte per cycle when accept_i is high, queuing output items
// ----------------------------------------------------------------------------
`include "gif_first_image_filter_unit_assert.svh"

module gif_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               first_image_only_i,
  output logic               push_o,
  output gif_pkg::gif_item_t item_o
);
  import gif_pkg::*;

  phase_e     phase_q, phase_d, eff_phase;
  logic [3:0] idx_q, idx_d, cur_idx;
  logic [9:0] btc_q, btc_d;
  logic [7:0] flags_q, flags_d;

  function automatic logic [9:0] table_bytes(input logic [7:0] flags);
    logic [9:0] base;
    base = 10'd2 << flags[2:0];
    return flags[7] ? ((base << 1) + base) : 10'd0;
  endfunction

  function automatic logic sig_ok(input logic [3:0] idx, input logic [7:0] b);
    logic ok;
    case (idx)
      4'd0:    ok = (b == CH_G);
      4'd1:    ok = (b == CH_I);
      4'd2:    ok = (b == CH_F);
      4'd3:    ok = (b == CH_8);
      4'd4:    ok = (b == CH_7) || (b == CH_9);
      4'd5:    ok = (b == CH_A);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // a block boundary byte picks the phase that handles this same byte
  always_comb begin
    eff_phase = phase_q;
    cur_idx   = idx_q;
    if (phase_q == PH_BOUNDARY) begin
      priority case (in_byte_i)
        BLK_IMAGE: begin
          eff_phase = PH_IMAGEDESC;
          cur_idx   = '0;
        end
        BLK_EXT:     eff_phase = PH_EXTINTRO;
        BLK_TRAILER: eff_phase = PH_TRAILER;
        default:     eff_phase = PH_CODESIZE;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    btc_d       = btc_q;
    flags_d     = flags_q;
    push_o      = 1'b0;
    item_o.op   = OP_PASS;
    item_o.data = in_byte_i;
    if (accept_i) begin
      priority if (phase_q == PH_DROPALL) begin
        push_o = 1'b0;
      end else if (phase_q == PH_COPYALL || btc_q != '0) begin
        if (phase_q != PH_COPYALL) begin
          btc_d = btc_q - 1'b1;
        end
        push_o = 1'b1;
      end else begin
        push_o  = 1'b1;
        phase_d = eff_phase;
        unique case (eff_phase)
          PH_SIGNATURE: begin
            if (!sig_ok(idx_q, in_byte_i)) begin
              phase_d = PH_COPYALL;
            end else if (idx_q >= 4'd5) begin
              phase_d = PH_SCREEN;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          PH_SCREEN: begin
            if (idx_q == 4'd4) begin
              flags_d = in_byte_i;
            end
            if (idx_q >= 4'd6) begin
              btc_d   = table_bytes(flags_q);
              phase_d = PH_BOUNDARY;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          PH_IMAGEDESC: begin
            if (cur_idx >= 4'd9) begin
              flags_d = in_byte_i;
              btc_d   = table_bytes(in_byte_i);
              phase_d = PH_BOUNDARY;
            end else begin
              idx_d = cur_idx + 1'b1;
            end
          end
          PH_CODESIZE: phase_d = PH_IMAGEDATA;
          PH_IMAGEDATA: begin
            btc_d = {2'b00, in_byte_i};
            if (in_byte_i == 8'd0) begin
              phase_d = first_image_only_i ? PH_TRAILER : PH_BOUNDARY;
            end
          end
          PH_TRAILER: begin
            item_o.op = OP_TRAILER;
            phase_d   = PH_DROPALL;
          end
          PH_EXTINTRO: phase_d = PH_EXTTYPE;
          PH_EXTTYPE:  phase_d = PH_EXTDATA;
          PH_EXTDATA: begin
            btc_d = {2'b00, in_byte_i};
            if (in_byte_i == 8'd0) begin
              phase_d = PH_BOUNDARY;
            end
          end
          default: begin
            phase_d = PH_DROPALL;
            push_o  = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIGNATURE;
      idx_q   <= '0;
      btc_q   <= '0;
      flags_q <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      btc_q   <= btc_d;
      flags_q <= flags_d;
    end
  end

  `GIF_ASSERT(a_drop_silent, phase_q == PH_DROPALL |-> !push_o, "transfer after trailer")
  `GIF_ASSERT(a_trailer_last, push_o && item_o.op == OP_TRAILER |=> phase_q == PH_DROPALL,
              "trailer not followed by drop phase")
  `GIF_ASSERT(a_btc_bound, btc_q <= 10'd768, "copy count out of range")

endmodule

/* rtl/core/gif_back.sv */
// ----------------------------------------------------------------------------
// gif output back end
// decodes queued items into output bytes and holds the result register
// ----------------------------------------------------------------------------
module gif_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  gif_pkg::gif_item_t item_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o
);
  import gif_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // refill when the register is free or its byte leaves this cycle
  assign q_pop_o = !q_empty_i && (!valid_q || pop_i);
  assign valid_d = q_pop_o || (valid_q && !pop_i);

  always_comb begin
    unique case (item_i.op)
      OP_TRAILER: byte_d = BLK_TRAILER;
      OP_PASS:    byte_d = item_i.data;
      default:    byte_d = item_i.data;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q <= byte_d;
    end
  end

  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;

endmodule

/* rtl/core/gif_first_image_filter_unit.sv */
// ----------------------------------------------------------------------------
// gif first image filter
// passes a gif byte stream and cuts it after the first image when enabled
// ----------------------------------------------------------------------------
// Takes one byte per clock while full is low and gives one byte per clock while
// pop is held; a pushed byte enters the queue, then the output register, before
// showing on out_byte_o. The parser's per-byte state update sets the rate. Items
// wait in a QueueDepth-entry queue and a one-entry output register, so full rises
// only after QueueDepth + 1 results stay unpopped. Users write first_image_only
// (address 0, reset 1) over the APB port only while the block is idle; unchecked.
module gif_first_image_filter_unit #(
  parameter int QueueDepth = gif_pkg::GIF_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gif_pkg::PADDR_W-1:0] paddr,
  input  logic [gif_pkg::PDATA_W-1:0] pwdata,
  output logic [gif_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte_i,
  input  logic                        pop,
  output logic                        empty,
  output logic [7:0]                  out_byte_o
);
  import gif_pkg::*;

  logic      fio_q;
  logic      cfg_sel, cfg_wr;
  logic      in_accept;
  logic      f_push, q_empty, q_pop;
  gif_item_t f_item, q_item;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1] == CFG_IDX_FIRST_IMAGE);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {{(PDATA_W-1){1'b0}}, fio_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fio_q <= 1'b1;
    end else if (cfg_wr) begin
      fio_q <= pwdata[0];
    end
  end

  assign in_accept = push && !full;

  gif_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .in_byte_i          (in_byte_i),
    .first_image_only_i (fio_q),
    .push_o             (f_push),
    .item_o             (f_item)
  );

  gif_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  gif_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .item_i     (q_item),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o)
  );

endmodule
